/* src/euclidean_nearest_template_top_macros.svh */
// ---------------------------------------------------------------------------
// Assertion macros for the nearest-template search block
// Shared property wrappers; every property is clocked on clock and
// disabled while reset is high.
// ---------------------------------------------------------------------------
`ifndef EUCLIDEAN_NEAREST_TEMPLATE_TOP_MACROS_SVH
`define EUCLIDEAN_NEAREST_TEMPLATE_TOP_MACROS_SVH

// Same-cycle implication
`define ENT_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication
`define ENT_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* src/ent_pkg.sv */
// ---------------------------------------------------------------------------
// ent_pkg
// Widths, limits and controller/datapath interface types for the
// nearest-template search block.
// ---------------------------------------------------------------------------
package ent_pkg;

   localparam int FEATURE_WIDTH = 16;
   localparam int MAX_TEMPLATES = 128;

   localparam int IDX_W  = 7;
   localparam int DIST_W = 24;
   localparam int ACC_W  = 48;
   localparam int DIFF_W = FEATURE_WIDTH + 1;
   localparam int SQ_W   = 2 * FEATURE_WIDTH;

   // one result bit per iteration of the root unit
   localparam int ROOT_STEPS = ACC_W / 2;
   localparam int ITER_W     = $clog2(ROOT_STEPS);

   localparam logic [ACC_W-1:0] ACC_MAX   = {ACC_W{1'b1}};
   localparam logic [ACC_W-1:0] ROOT_BIT0 = {2'b01, {(ACC_W-2){1'b0}}};
   localparam logic [IDX_W-1:0] CNT_MAX   = IDX_W'(MAX_TEMPLATES - 1);
   localparam logic [ITER_W-1:0] ITER_LAST = ITER_W'(ROOT_STEPS - 1);

   // commands from controller to datapath
   typedef struct packed {
      logic accept;     // input transfer this cycle
      logic root_load;  // fold last square, start the root
      logic root_step;  // one root iteration
      logic finish;     // update best, load result register
   } ent_cmd_type;

   // status from datapath to controller
   typedef struct packed {
      logic out_free;   // result register can take a new result
   } ent_status_type;

endpackage

/* src/ent_ctrl.sv */
// ---------------------------------------------------------------------------
// ent_ctrl
// Sequencer: streams elements, then folds the last square, runs the
// square-root iterations and hands the result to the output register.
// ---------------------------------------------------------------------------
`include "euclidean_nearest_template_top_macros.svh"

module ent_ctrl import ent_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   input  logic           req_last_element,
   output logic           req_stall,
   input  ent_status_type status,
   output ent_cmd_type    cmd
);

   typedef enum logic [1:0] {
      ST_ACCEPT,
      ST_FOLD,
      ST_ROOT,
      ST_FINISH
   } state_type;

   state_type         state_ff, state_in;
   logic [ITER_W-1:0] iter_ff, iter_in;
   logic              req_stall_ff, req_stall_in;

   // next state
   always_comb begin
      state_in = state_ff;
      iter_in  = iter_ff;
      case (state_ff)
         ST_ACCEPT: begin
            if (req_valid && req_last_element) begin
               state_in = ST_FOLD;
            end
         end
         ST_FOLD: begin
            state_in = ST_ROOT;
            iter_in  = '0;
         end
         ST_ROOT: begin
            iter_in = iter_ff + ITER_W'(1);
            if (iter_ff == ITER_LAST) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (status.out_free) begin
               state_in = ST_ACCEPT;
            end
         end
         default: begin
            state_in = ST_ACCEPT;
         end
      endcase
      req_stall_in = (state_in != ST_ACCEPT);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_ACCEPT;
         iter_ff      <= '0;
         req_stall_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         iter_ff      <= iter_in;
         req_stall_ff <= req_stall_in;
      end
   end

   // commands
   assign req_stall      = req_stall_ff;
   assign cmd.accept     = (state_ff == ST_ACCEPT) && req_valid;
   assign cmd.root_load  = (state_ff == ST_FOLD);
   assign cmd.root_step  = (state_ff == ST_ROOT);
   assign cmd.finish     = (state_ff == ST_FINISH) && status.out_free;

   `ENT_ASSERT_NOW(a_stall_matches_state, state_ff != ST_ACCEPT, req_stall_ff,
      "input not stalled outside accept state")
   `ENT_ASSERT_NEXT(a_last_starts_fold, cmd.accept && req_last_element,
      state_ff == ST_FOLD, "last element did not start the fold")
   `ENT_ASSERT_NEXT(a_fold_to_root, state_ff == ST_FOLD,
      state_ff == ST_ROOT && iter_ff == '0, "fold not followed by root start")

endmodule

/* src/ent_dpath.sv */
// ---------------------------------------------------------------------------
// ent_dpath
// Square/accumulate pipeline, iterative floor square root, best-template
// tracking and the result register.
// ---------------------------------------------------------------------------
`include "euclidean_nearest_template_top_macros.svh"

module ent_dpath import ent_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  ent_cmd_type              cmd,
   output ent_status_type           status,
   input  logic signed [FEATURE_WIDTH-1:0] req_query_value,
   input  logic signed [FEATURE_WIDTH-1:0] req_template_value,
   input  logic                     req_last_template,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [DIST_W-1:0]        rsp_template_distance,
   output logic [IDX_W-1:0]         rsp_best_index,
   output logic [DIST_W-1:0]        rsp_best_distance,
   output logic                     rsp_query_done
);

   logic signed [DIFF_W-1:0] diff;
   logic [FEATURE_WIDTH-1:0] mag;
   logic [SQ_W-1:0]          sq_ff;
   logic                     sq_valid_ff;
   logic                     last_tp_ff;
   logic [ACC_W:0]           sum_wide;
   logic [ACC_W-1:0]         sum_sat;
   logic [ACC_W-1:0]         acc_ff, acc_in;
   logic [ACC_W-1:0]         rem_ff, rem_in;
   logic [ACC_W-1:0]         root_ff, root_in;
   logic [ACC_W-1:0]         bit_ff, bit_in;
   logic [ACC_W:0]           trial;
   logic [DIST_W-1:0]        tpl_dist;
   logic                     take;
   logic [DIST_W-1:0]        min_ff;
   logic [IDX_W-1:0]         min_idx_ff;
   logic [IDX_W-1:0]         count_ff;
   logic                     rsp_valid_ff;
   logic [DIST_W-1:0]        out_dist_ff, out_best_ff;
   logic [IDX_W-1:0]         out_idx_ff;
   logic                     out_done_ff;

   // stage 1: absolute difference and square
   assign diff = DIFF_W'(req_query_value) - DIFF_W'(req_template_value);
   assign mag  = diff[DIFF_W-1] ? FEATURE_WIDTH'(-diff) : FEATURE_WIDTH'(diff);

   always_ff @(posedge clock) begin
      if (reset) begin
         sq_valid_ff <= 1'b0;
      end else begin
         sq_valid_ff <= cmd.accept;
      end
      if (cmd.accept) begin
         sq_ff      <= mag * mag;
         last_tp_ff <= req_last_template;
      end
   end

   // stage 2: saturating accumulate, cleared when handed to the root unit
   assign sum_wide = {1'b0, acc_ff} + (ACC_W+1)'(sq_ff);
   assign sum_sat  = sum_wide[ACC_W] ? ACC_MAX : sum_wide[ACC_W-1:0];

   always_comb begin
      acc_in = acc_ff;
      if (cmd.root_load) begin
         acc_in = '0;
      end else if (sq_valid_ff) begin
         acc_in = sum_sat;
      end
   end

   // floor square root, one result bit per step
   assign trial = {1'b0, root_ff} + {1'b0, bit_ff};

   always_comb begin
      rem_in  = rem_ff;
      root_in = root_ff;
      bit_in  = bit_ff;
      if (cmd.root_load) begin
         rem_in  = sum_sat;
         root_in = '0;
         bit_in  = ROOT_BIT0;
      end else if (cmd.root_step) begin
         if ({1'b0, rem_ff} >= trial) begin
            rem_in  = rem_ff - trial[ACC_W-1:0];
            root_in = (root_ff >> 1) + bit_ff;
         end else begin
            root_in = root_ff >> 1;
         end
         bit_in = bit_ff >> 2;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= '0;
      end else begin
         acc_ff <= acc_in;
      end
      rem_ff  <= rem_in;
      root_ff <= root_in;
      bit_ff  <= bit_in;
   end

   // best-template tracking; a tie goes to the later template
   assign tpl_dist = root_ff[DIST_W-1:0];
   assign take     = (count_ff == '0) || (min_ff >= tpl_dist);

   always_ff @(posedge clock) begin
      if (reset) begin
         min_ff     <= '0;
         min_idx_ff <= '0;
         count_ff   <= '0;
      end else if (cmd.finish) begin
         if (take) begin
            min_ff     <= tpl_dist;
            min_idx_ff <= count_ff;
         end
         if (last_tp_ff) begin
            count_ff <= '0;
         end else if (count_ff < CNT_MAX) begin
            count_ff <= count_ff + IDX_W'(1);
         end
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.finish) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
      if (cmd.finish) begin
         out_dist_ff <= tpl_dist;
         out_idx_ff  <= take ? count_ff : min_idx_ff;
         out_best_ff <= take ? tpl_dist : min_ff;
         out_done_ff <= last_tp_ff;
      end
   end

   assign status.out_free       = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid             = rsp_valid_ff;
   assign rsp_template_distance = out_dist_ff;
   assign rsp_best_index        = out_idx_ff;
   assign rsp_best_distance     = out_best_ff;
   assign rsp_query_done        = out_done_ff;

   `ENT_ASSERT_NEXT(a_fold_clears_acc, cmd.root_load, acc_ff == '0,
      "accumulator not cleared after fold")
   `ENT_ASSERT_NEXT(a_finish_shows_result, cmd.finish, rsp_valid_ff,
      "finished template produced no result")
   `ENT_ASSERT_NEXT(a_best_not_worse, cmd.finish, out_best_ff <= out_dist_ff,
      "best distance exceeds template distance")

endmodule

/* src/euclidean_nearest_template_top.sv */
// After the last element of a template is transferred come the fold, the square-root
// iterations and the result load; the load waits while an earlier result still waits in
// the stalled result register. Throughput: one element per cycle inside a template; each
// template end stalls input through the fold, 24 root iterations and the result load.
// Reset (synchronous, active high) clears the accumulator, template count, best
// distance/index and the result valid; no clearing pass is needed.
// ---------------------------------------------------------------------------
// euclidean_nearest_template_top
// Nearest-template search by Euclidean distance over streamed elements.
// ---------------------------------------------------------------------------
module euclidean_nearest_template_top import ent_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic signed [FEATURE_WIDTH-1:0] req_query_value,
   input  logic signed [FEATURE_WIDTH-1:0] req_template_value,
   input  logic                     req_last_element,
   input  logic                     req_last_template,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [DIST_W-1:0]        rsp_template_distance,
   output logic [IDX_W-1:0]         rsp_best_index,
   output logic [DIST_W-1:0]        rsp_best_distance,
   output logic                     rsp_query_done
);

   ent_cmd_type    cmd;
   ent_status_type status;

   // sequencer
   ent_ctrl u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_last_element (req_last_element),
      .req_stall        (req_stall),
      .status           (status),
      .cmd              (cmd)
   );

   // arithmetic and result register
   ent_dpath u_dpath (
      .clock                 (clock),
      .reset                 (reset),
      .cmd                   (cmd),
      .status                (status),
      .req_query_value       (req_query_value),
      .req_template_value    (req_template_value),
      .req_last_template     (req_last_template),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_template_distance (rsp_template_distance),
      .rsp_best_index        (rsp_best_index),
      .rsp_best_distance     (rsp_best_distance),
      .rsp_query_done        (rsp_query_done)
   );

endmodule

/* tb/sv/ent_tb_pkg.sv */
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// ent_tb_pkg
// Predictor and result store for the nearest-template search testbench:
// tracks the running sum of squares, template index and best match, and
// checks each result transfer against the oldest expected result.
// ---------------------------------------------------------------------------
package ent_tb_pkg;
   import ent_pkg::*;

   typedef struct {
      logic [DIST_W-1:0] tpl_dist;
      logic [IDX_W-1:0]  idx;
      logic [DIST_W-1:0] best;
      logic              done;
   } match_result_type;

   class nearest_scoreboard;
      longint unsigned   sum_sq    = 0;
      logic [IDX_W-1:0]  tpl_index = '0;
      logic [DIST_W-1:0] best_dist = '0;
      logic [IDX_W-1:0]  best_idx  = '0;
      match_result_type  expected_matches[$];
      int                mismatches = 0;
      int                checked    = 0;
      int                queries    = 0;
      int                ties       = 0;

      // advance the predicted state by one accepted element
      function void note_input(logic signed [FEATURE_WIDTH-1:0] q,
                               logic signed [FEATURE_WIDTH-1:0] t,
                               logic last_el, logic last_tpl);
         longint            diff;
         longint unsigned   sq;
         longint unsigned   total;
         longint unsigned   trial;
         logic [DIST_W-1:0] root;
         diff  = longint'(q) - longint'(t);
         sq    = (diff < 0) ? longint'(-diff) : longint'(diff);
         sq    = sq * sq;
         total = sum_sq + sq;
         // accumulator clamps at all ones
         if (total > longint'(ACC_MAX))
            total = longint'(ACC_MAX);
         sum_sq = total;
         if (!last_el)
            return;
         // floor square root, one result bit at a time from the top
         root = '0;
         for (int b = DIST_W - 1; b >= 0; b--) begin
            trial = longint'(root) | (64'd1 << b);
            if (trial * trial <= sum_sq)
               root = trial[DIST_W-1:0];
         end
         if (tpl_index != '0 && best_dist == root)
            ties++;
         // first template takes the best outright; equal distance goes to the later one
         if (tpl_index == '0 || best_dist >= root) begin
            best_dist = root;
            best_idx  = tpl_index;
         end
         expected_matches.push_back('{root, best_idx, best_dist, last_tpl});
         sum_sq = 0;
         if (last_tpl)
            tpl_index = '0;
         else if (tpl_index != CNT_MAX)
            tpl_index++;
      endfunction

      // compare one result transfer with the oldest expectation
      function void check_result(logic [DIST_W-1:0] tpl_dist, logic [IDX_W-1:0] idx,
                                 logic [DIST_W-1:0] best, logic done);
         match_result_type want;
         checked++;
         if (expected_matches.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result: dist %0d idx %0d best %0d done %0b",
                        tpl_dist, idx, best, done);
            return;
         end
         want = expected_matches.pop_front();
         if (want.done)
            queries++;
         if (tpl_dist !== want.tpl_dist || idx !== want.idx || best !== want.best ||
             done !== want.done) begin
            mismatches++;
            if (mismatches <= 10)
               $display("result %0d mismatch: exp dist %0d idx %0d best %0d done %0b, %s",
                        checked, want.tpl_dist, want.idx, want.best, want.done,
                        $sformatf("got dist %0d idx %0d best %0d done %0b",
                                  tpl_dist, idx, best, done));
         end
      endfunction

      function int pending();
         return expected_matches.size();
      endfunction
   endclass

endpackage

/* tb/sv/tb_top.sv */
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_top
// Self-checking bench for euclidean_nearest_template_top: streams query and
// template elements with random gaps and result back-pressure, predicts every
// distance and best match, and checks them in order.
// ---------------------------------------------------------------------------
module tb_top import ent_pkg::*, ent_tb_pkg::*;;

   typedef enum int {VAL_FULL, VAL_SMALL, VAL_EXTREME, VAL_MIXED} value_mix_type;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int RANDOM_ITEMS   = 600;

   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            req_valid = 1'b0;
   logic                            req_stall;
   logic signed [FEATURE_WIDTH-1:0] req_query_value = '0;
   logic signed [FEATURE_WIDTH-1:0] req_template_value = '0;
   logic                            req_last_element = 1'b0;
   logic                            req_last_template = 1'b0;
   logic                            rsp_valid;
   logic                            rsp_stall = 1'b0;
   logic [DIST_W-1:0]               rsp_template_distance;
   logic [IDX_W-1:0]                rsp_best_index;
   logic [DIST_W-1:0]               rsp_best_distance;
   logic                            rsp_query_done;

   nearest_scoreboard sb;
   bit                quiet = 1'b0;
   int                sent = 0;
   int                idle_cycles = 0;

   euclidean_nearest_template_top dut (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_stall             (req_stall),
      .req_query_value       (req_query_value),
      .req_template_value    (req_template_value),
      .req_last_element      (req_last_element),
      .req_last_template     (req_last_template),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_template_distance (rsp_template_distance),
      .rsp_best_index        (rsp_best_index),
      .rsp_best_distance     (rsp_best_distance),
      .rsp_query_done        (rsp_query_done)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // gap length per transfer; some stretches run without gaps
   function automatic int draw_gap();
      if (quiet || $urandom_range(0, 3) == 0)
         return 0;
      return $urandom_range(0, 17);
   endfunction

   function automatic logic signed [FEATURE_WIDTH-1:0] pick_value(value_mix_type mix);
      value_mix_type pick;
      int            tmp;
      pick = (mix == VAL_MIXED) ? value_mix_type'($urandom_range(0, 2)) : mix;
      case (pick)
         VAL_FULL: begin
            tmp = int'($urandom);
         end
         VAL_SMALL: begin
            tmp = int'($urandom_range(0, 6)) - 3;
         end
         default: begin
            case ($urandom_range(0, 4))
               0:       tmp = 32767;
               1:       tmp = -32768;
               2:       tmp = 1;
               3:       tmp = -1;
               default: tmp = 0;
            endcase
         end
      endcase
      return tmp[FEATURE_WIDTH-1:0];
   endfunction

   // one element transfer, after a random gap
   task automatic send_item(logic signed [FEATURE_WIDTH-1:0] q,
                            logic signed [FEATURE_WIDTH-1:0] t,
                            logic last_el, logic last_tpl);
      int gap;
      gap = draw_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid          <= 1'b1;
      req_query_value    <= q;
      req_template_value <= t;
      req_last_element   <= last_el;
      req_last_template  <= last_tpl;
      do @(posedge clock); while (req_stall !== 1'b0);
      sb.note_input(q, t, last_el, last_tpl);
      sent++;
   endtask

   // hold the sender until every expected result has come back
   task automatic drain_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (sb.pending() != 0);
   endtask

   // result side: random stall before each transfer
   initial begin
      int gap;
      wait (reset == 1'b0);
      forever begin
         gap = draw_gap();
         if (gap > 0) begin
            rsp_stall <= 1'b1;
            repeat (gap) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (rsp_valid !== 1'b1);
         sb.check_result(rsp_template_distance, rsp_best_index, rsp_best_distance,
                         rsp_query_done);
      end
   end

   // watchdog on cycles with no transfer on either side
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("timeout after %0d cycles without a transfer", WATCHDOG_LIMIT);
         $display("euclidean_nearest_template_top regression: fail");
         $finish;
      end
   end

   initial begin
      int            rand_items;
      int            n_tpl;
      int            len;
      bit            noisy;
      bit            last_el;
      bit            last_tpl;
      value_mix_type mix;
      sb = new;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // field extremes and a tie at the top of the range
      send_item(16'sh7FFF, -16'sh8000, 1'b1, 1'b0);
      send_item(-16'sh8000, 16'sh7FFF, 1'b1, 1'b0);
      send_item(16'sd0, 16'sd0, 1'b1, 1'b0);
      send_item(16'sd0, 16'sd0, 1'b1, 1'b1);
      // last_template on an inner element is ignored; ties go to the later index
      send_item(16'sd256, 16'sd0, 1'b0, 1'b1);
      send_item(-16'sd256, 16'sd0, 1'b0, 1'b0);
      send_item(16'sd100, 16'sd100, 1'b1, 1'b0);
      send_item(16'sd1, 16'sd0, 1'b1, 1'b0);
      send_item(16'sd0, 16'sd1, 1'b1, 1'b0);
      send_item(16'sd2, 16'sd0, 1'b1, 1'b1);
      // single-template queries
      send_item(-16'sd1, -16'sd1, 1'b1, 1'b1);
      send_item(-16'sh8000, -16'sh8000, 1'b0, 1'b0);
      send_item(16'sh7FFF, 16'sh7FFF, 1'b0, 1'b0);
      send_item(-16'sh8000, 16'sd0, 1'b1, 1'b1);

      // more templates than the index can count
      for (int k = 0; k < MAX_TEMPLATES + 7; k++)
         send_item(pick_value(VAL_MIXED), pick_value(VAL_SMALL), 1'b1,
                   k == MAX_TEMPLATES + 6);

      // let every pending result come back before the random phase
      drain_results();

      // random queries, some with stray last_template bits
      rand_items = 0;
      while (rand_items < RANDOM_ITEMS) begin
         n_tpl = $urandom_range(1, 10);
         mix   = value_mix_type'($urandom_range(0, 3));
         noisy = ($urandom_range(0, 7) == 0);
         quiet = ($urandom_range(0, 4) == 0);
         for (int k = 0; k < n_tpl; k++) begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
            for (int e = 0; e < len; e++) begin
               last_el = (e == len - 1);
               if (noisy)
                  last_tpl = $urandom_range(0, 1);
               else
                  last_tpl = last_el ? (k == n_tpl - 1) : ($urandom_range(0, 19) == 0);
               send_item(pick_value(mix), pick_value(mix), last_el, last_tpl);
               rand_items++;
            end
         end
         if ($urandom_range(0, 7) == 0)
            drain_results();
      end
      quiet = 1'b0;

      drain_results();
      repeat (40) @(posedge clock);
      $display("%0d element transfers, %0d results checked over %0d completed queries",
               sent, sb.checked, sb.queries);
      $display("template index held at its limit in a long query; %0d distance ties seen",
               sb.ties);
      if (sb.mismatches == 0 && sb.pending() == 0)
         $display("euclidean_nearest_template_top regression: pass");
      else
         $display("euclidean_nearest_template_top regression: fail");
      $finish;
   end

endmodule
